// ----- sv/u8hash_pkg.sv -----
// shared types, constants and helpers for the utf-8 to utf-16 string hash
`timescale 1ns / 1ps
`default_nettype none

package u8hash_pkg;

    // lead byte thresholds
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;

    // payload masks
    localparam logic [7:0] MASK4_LEAD = 8'h07;
    localparam logic [7:0] MASK3_LEAD = 8'h0F;
    localparam logic [7:0] MASK2_LEAD = 8'h1F;
    localparam logic [7:0] MASK_CONT  = 8'h3F;

    // surrogate constants
    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0] HI_SURR   = 16'hD800;
    localparam logic [15:0] LO_SURR   = 16'hDC00;
    localparam logic [9:0]  SURR_MASK = 10'h3FF;

    // hash multiplier shift: h*31 = (h << 5) - h
    localparam int HASH_SHIFT = 5;

    // sequence lengths
    localparam logic [2:0] LEN1 = 3'd1;
    localparam logic [2:0] LEN2 = 3'd2;
    localparam logic [2:0] LEN3 = 3'd3;
    localparam logic [2:0] LEN4 = 3'd4;

    // one decoded code point, as one or two utf-16 units
    typedef struct packed {
        logic        pair;
        logic [15:0] unit_first;
        logic [15:0] unit_second;
        logic        last;
    } u8hash_entry_t;

    // emitter status seen by the top level
    typedef struct packed {
        logic [1:0] fifo_count;
        logic       second_half;
        logic       hash_zero;
    } u8hash_status_t;

    // sequence length from the lead byte
    function automatic logic [2:0] seq_length(input logic [7:0] lead);
        logic [2:0] len;
        if (lead >= LEAD4_MIN) begin
            len = LEN4;
        end else if (lead >= LEAD3_MIN) begin
            len = LEN3;
        end else if (lead >= LEAD2_MIN) begin
            len = LEN2;
        end else begin
            len = LEN1;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- sv/u8hash_decode.sv -----
// utf-8 byte buffering and lenient code point decode
`timescale 1ns / 1ps
`default_nettype none

module u8hash_decode (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_accept,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       in_last,
    output logic                            push,
    output u8hash_pkg::u8hash_entry_t       push_entry
);
    import u8hash_pkg::*;

    logic [7:0]  pend_reg [3];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    logic [7:0]  lead;
    logic [2:0]  need;
    logic [2:0]  have_len;
    logic        complete;
    logic [20:0] cp;
    logic [20:0] v;
    logic [10:0] v_hi;

    // lead byte and completion check
    always_comb begin
        lead     = (count_reg == 2'd0) ? in_byte : pend_reg[0];
        need     = seq_length(lead);
        have_len = {1'b0, count_reg} + 3'd1;
        complete = (have_len >= need) || in_last;
    end

    // decode with the form that the gathered bytes allow
    always_comb begin
        case (have_len)
            LEN4: cp = {(pend_reg[0][2:0] & MASK4_LEAD[2:0]),
                        (pend_reg[1][5:0] & MASK_CONT[5:0]),
                        (pend_reg[2][5:0] & MASK_CONT[5:0]),
                        (in_byte[5:0] & MASK_CONT[5:0])};
            LEN3: cp = {5'd0, (pend_reg[0][3:0] & MASK3_LEAD[3:0]),
                        (pend_reg[1][5:0] & MASK_CONT[5:0]),
                        (in_byte[5:0] & MASK_CONT[5:0])};
            LEN2: cp = {10'd0, (pend_reg[0][4:0] & MASK2_LEAD[4:0]),
                        (in_byte[5:0] & MASK_CONT[5:0])};
            default: cp = {13'd0, in_byte};
        endcase
    end

    // split into units, surrogates wrap at 16 bits
    always_comb begin
        v    = cp - SUPP_BASE;
        v_hi = v[20:10];
        push_entry.pair        = (cp >= SUPP_BASE);
        push_entry.unit_first  = push_entry.pair ? (HI_SURR + {5'd0, v_hi}) : cp[15:0];
        push_entry.unit_second = LO_SURR + {6'd0, (v[9:0] & SURR_MASK)};
        push_entry.last        = in_last;
        push                   = in_accept && complete;
    end

    // buffer count
    always_comb begin
        count_next = count_reg;
        if (in_accept) begin
            count_next = complete ? 2'd0 : have_len[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // pending bytes, no reset
    always_ff @(posedge aclk) begin
        if (in_accept && !complete) begin
            pend_reg[count_reg] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// ----- sv/u8hash_emit.sv -----
// two-entry queue of decoded code points and the hashing unit emitter
`timescale 1ns / 1ps
`default_nettype none

module u8hash_emit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire u8hash_pkg::u8hash_entry_t  push_entry,
    output logic                            full,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [15:0]                     out_unit,
    output logic [31:0]                     out_hash,
    output logic                            out_final,
    output u8hash_pkg::u8hash_status_t      status
);
    import u8hash_pkg::*;

    u8hash_entry_t fifo_mem [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          sub_reg;
    logic          sub_next;
    logic [31:0]   hash_reg;
    logic [31:0]   hash_next;
    logic          valid_reg;
    logic [15:0]   unit_reg;
    logic [31:0]   out_hash_reg;
    logic          final_reg;

    u8hash_entry_t head;
    logic          load;
    logic          pop;
    logic [15:0]   unit;
    logic          fin;
    logic [31:0]   h31;

    // select the next unit and fold it into the hash, which clears after the final unit
    always_comb begin
        head  = fifo_mem[rd_ptr_reg];
        load  = (count_reg != 2'd0) && (!valid_reg || out_ready);
        unit  = sub_reg ? head.unit_second : head.unit_first;
        fin   = head.last && (!head.pair || sub_reg);
        pop   = load && (!head.pair || sub_reg);
        h31   = (hash_reg << HASH_SHIFT) - hash_reg + {16'd0, unit};
        hash_next  = hash_reg;
        sub_next   = sub_reg;
        if (load) begin
            hash_next = fin ? 32'd0 : h31;
            sub_next  = !pop;
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_entry;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
            hash_reg   <= 32'd0;
            valid_reg  <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
            sub_reg   <= sub_next;
            hash_reg  <= hash_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output beat payload
    always_ff @(posedge aclk) begin
        if (load) begin
            unit_reg     <= unit;
            out_hash_reg <= h31;
            final_reg    <= fin;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign out_valid = valid_reg;
    assign out_unit  = unit_reg;
    assign out_hash  = out_hash_reg;
    assign out_final = final_reg;

    assign status.fifo_count  = count_reg;
    assign status.second_half = sub_reg;
    assign status.hash_zero   = (hash_reg == 32'd0);

endmodule

`default_nettype wire

// ----- sv/utf8_to_utf16_string_hash.sv -----
// utf-8 string to utf-16 units with running 31-multiplier hash, top level
// a byte that completes a code point is written into the emitter queue; its first unit then goes to the output register
// throughput: one byte per cycle while the queue is not full; a supplementary code point needs an output beat
//   for each of its two units, set by the single hash update per beat in the emitter
// a byte that only fills the sequence buffer gives no output beat
// reset: synchronous active-low aresetn clears buffer count, queue, hash and output valid
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_string_hash (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [15:0] code_unit, [47:16] running_hash
    output logic             m_tlast    // final_unit
);
    import u8hash_pkg::*;

    logic           in_accept;
    logic           push;
    u8hash_entry_t  push_entry;
    logic           full;
    logic [15:0]    out_unit;
    logic [31:0]    out_hash;
    u8hash_status_t status;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    // byte buffering and decode
    u8hash_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    // unit queue, hash and output register
    u8hash_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_unit   (out_unit),
        .out_hash   (out_hash),
        .out_final  (m_tlast),
        .status     (status)
    );

    assign m_tdata = {out_hash, out_unit};

    // checks
    a_hash_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.fifo_count != 2'd0) && (!m_tvalid || m_tready) && status.second_half &&
        (status.fifo_count == 2'd1) && !push |=> status.fifo_count == 2'd0)
        else $error("queue did not drain after second surrogate");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.fifo_count != 2'd3)
        else $error("queue count overflow");

    a_second_half_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        status.second_half |-> status.fifo_count != 2'd0)
        else $error("second surrogate pending with empty queue");

    a_final_clears_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && $rose(m_tvalid) |-> status.hash_zero)
        else $error("hash not cleared after final unit");

endmodule

`default_nettype wire
